// File: rtl/mtep_pkg.sv
// mtep_pkg: shared types, phase codes and the channel data length table
// for the midi track event parser; no dependencies
package mtep_pkg;

    localparam logic [2:0] PH_DELTA  = 3'd0;
    localparam logic [2:0] PH_STATUS = 3'd1;
    localparam logic [2:0] PH_MTYPE  = 3'd2;
    localparam logic [2:0] PH_MLEN   = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;

    localparam logic [7:0] META_MARK = 8'hFF;
    localparam logic [7:0] META_END  = 8'd68;
    localparam logic [7:0] META_STOP = 8'd46;

    localparam logic [1:0] HALT_END  = 2'b01;
    localparam logic [1:0] HALT_STOP = 2'b10;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_STOP = 2'd2;

    typedef struct packed {
        logic [2:0]  phase;
        logic [31:0] delta;
        logic [7:0]  run_status;
        logic [1:0]  halt;
        logic [7:0]  pend_status;
        logic        pend_meta;
        logic [7:0]  left;
        logic [7:0]  count;
    } ctl_t;

    localparam int CTL_W = $bits(ctl_t);

    typedef struct packed {
        logic [3:0]  event_track;
        logic [31:0] delta_time;
        logic [7:0]  status_byte;
        logic        is_meta;
        logic [7:0]  data_0;
        logic [7:0]  data_1;
        logic [7:0]  data_2;
        logic [7:0]  data_3;
        logic [7:0]  data_count;
        logic        truncated;
        logic [1:0]  stop_kind;
    } event_t;

    // data bytes per channel event, indexed by status bits 6:4
    function automatic logic [1:0] data_len(input logic [2:0] idx);
        logic [1:0] len;
        case (idx)
            3'd4, 3'd5: len = 2'd1;
            default:    len = 2'd2;
        endcase
        return len;
    endfunction

endpackage

// File: rtl/mtep_if.sv
// mtep_in_if and mtep_out_if: valid/ready channels for sequence bytes and events
// no dependencies
interface mtep_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] track;
    logic [7:0] seq_byte;

    modport source (output valid, output track, output seq_byte, input ready);
    modport sink (input valid, input track, input seq_byte, output ready);
endinterface

interface mtep_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  event_track;
    logic [31:0] delta_time;
    logic [7:0]  status_byte;
    logic        is_meta;
    logic [7:0]  data_0;
    logic [7:0]  data_1;
    logic [7:0]  data_2;
    logic [7:0]  data_3;
    logic [7:0]  data_count;
    logic        truncated;
    logic [1:0]  stop_kind;

    modport source (output valid, output event_track, output delta_time, output status_byte,
                    output is_meta, output data_0, output data_1, output data_2, output data_3,
                    output data_count, output truncated, output stop_kind, input ready);
    modport sink (input valid, input event_track, input delta_time, input status_byte,
                  input is_meta, input data_0, input data_1, input data_2, input data_3,
                  input data_count, input truncated, input stop_kind, output ready);
endinterface

// File: rtl/midi_track_event_parser_core.sv
// Parses per-track midi sequence bytes into events, one byte accepted every clock cycle.
// Each track's parse state sits in one ram entry read in the cycle after the byte is accepted;
// the byte is applied and the entry written back in that next cycle, with the last write
// forwarded when consecutive bytes hit the same track. Entries carry a valid bit cleared
// at reset, so no clearing pass is needed. An event is pushed when its final byte is applied
// and leaves through a two-entry output queue; input is held off only when that queue
// backs up. Bytes for tracks at or above TRACKS, and for halted tracks, give no event.
// depends on mtep_pkg, mtep_if, mtep_ram, mtep_step
module midi_track_event_parser_core #(
    parameter int TRACKS   = 16,
    parameter int MAX_DATA = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    mtep_in_if.sink         in_ch,
    mtep_out_if.source      out_ch
);

    localparam int AW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int CW = 8 * MAX_DATA;
    localparam int SW = mtep_pkg::CTL_W + CW;

    logic                   in_fire;
    logic                   pop;
    logic                   push;
    logic                   we;

    logic                   s1_valid_reg;
    logic                   s1_hit_reg;
    logic [AW-1:0]          s1_addr_reg;
    logic [3:0]             s1_track_reg;
    logic [7:0]             s1_byte_reg;

    logic                   wr_valid_reg;
    logic [AW-1:0]          wr_addr_reg;
    logic [SW-1:0]          wr_data_reg;
    logic [TRACKS-1:0]      entry_valid_reg;

    logic [SW-1:0]          rdata;
    logic [SW-1:0]          cur_state;
    logic [SW-1:0]          wdata;
    mtep_pkg::ctl_t         nxt_ctl;
    logic [CW-1:0]          nxt_cap;
    logic                   emit;
    mtep_pkg::event_t       result;

    mtep_pkg::event_t       q_reg [2];
    logic                   q_wr_reg;
    logic                   q_rd_reg;
    logic [1:0]             q_count_reg;
    logic [1:0]             q_count_next;
    mtep_pkg::event_t       head;

    assign in_fire = in_ch.valid && in_ch.ready;
    assign pop     = out_ch.valid && out_ch.ready;

    assign in_ch.ready = (q_count_reg == 2'd0)
                      || (q_count_reg == 2'd1 && (!s1_valid_reg || pop))
                      || (q_count_reg == 2'd2 && pop && !s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_hit_reg   <= (32'(in_ch.track) < TRACKS);
            s1_addr_reg  <= AW'(in_ch.track);
            s1_track_reg <= in_ch.track;
            s1_byte_reg  <= in_ch.seq_byte;
        end
    end

    mtep_ram #(
        .WIDTH (SW),
        .DEPTH (TRACKS)
    ) u_state_ram (
        .clk   (clk),
        .we    (we),
        .waddr (s1_addr_reg),
        .wdata (wdata),
        .re    (in_fire),
        .raddr (AW'(in_ch.track)),
        .rdata (rdata)
    );

    always_comb
    begin
        if (wr_valid_reg && wr_addr_reg == s1_addr_reg)
        begin
            cur_state = wr_data_reg;
        end
        else if (entry_valid_reg[s1_addr_reg])
        begin
            cur_state = rdata;
        end
        else
        begin
            cur_state = '0;
        end
    end

    mtep_step #(
        .MAX_DATA (MAX_DATA)
    ) u_step (
        .cur_ctl  (mtep_pkg::ctl_t'(cur_state[SW-1:CW])),
        .cur_cap  (cur_state[CW-1:0]),
        .trk      (s1_track_reg),
        .seq_byte (s1_byte_reg),
        .nxt_ctl  (nxt_ctl),
        .nxt_cap  (nxt_cap),
        .emit     (emit),
        .result   (result)
    );

    assign we    = s1_valid_reg && s1_hit_reg;
    assign wdata = {nxt_ctl, nxt_cap};
    assign push  = we && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_valid_reg    <= 1'b0;
            entry_valid_reg <= '0;
        end
        else
        begin
            wr_valid_reg <= we;
            if (we)
            begin
                entry_valid_reg[s1_addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            wr_addr_reg <= s1_addr_reg;
            wr_data_reg <= wdata;
        end
    end

    // output queue
    always_comb
    begin
        q_count_next = q_count_reg;
        if (push && !pop)
        begin
            q_count_next = q_count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            q_count_next = q_count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_count_reg <= 2'd0;
            q_wr_reg    <= 1'b0;
            q_rd_reg    <= 1'b0;
        end
        else
        begin
            q_count_reg <= q_count_next;
            if (push)
            begin
                q_wr_reg <= ~q_wr_reg;
            end
            if (pop)
            begin
                q_rd_reg <= ~q_rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[q_wr_reg] <= result;
        end
    end

    assign head = q_reg[q_rd_reg];

    assign out_ch.valid       = (q_count_reg != 2'd0);
    assign out_ch.event_track = head.event_track;
    assign out_ch.delta_time  = head.delta_time;
    assign out_ch.status_byte = head.status_byte;
    assign out_ch.is_meta     = head.is_meta;
    assign out_ch.data_0      = head.data_0;
    assign out_ch.data_1      = head.data_1;
    assign out_ch.data_2      = head.data_2;
    assign out_ch.data_3      = head.data_3;
    assign out_ch.data_count  = head.data_count;
    assign out_ch.truncated   = head.truncated;
    assign out_ch.stop_kind   = head.stop_kind;

endmodule

// File: rtl/mtep_ram.sv
// mtep_ram: generic single write port, single read port ram with registered read
// no dependencies
module mtep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/mtep_step.sv
// mtep_step: per-byte parse update of one track's state and event assembly
// depends on mtep_pkg
module mtep_step #(
    parameter int MAX_DATA = 4
) (
    input  mtep_pkg::ctl_t          cur_ctl,
    input  logic [8*MAX_DATA-1:0]   cur_cap,
    input  logic [3:0]              trk,
    input  logic [7:0]              seq_byte,
    output mtep_pkg::ctl_t          nxt_ctl,
    output logic [8*MAX_DATA-1:0]   nxt_cap,
    output logic                    emit,
    output mtep_pkg::event_t        result
);

    mtep_pkg::ctl_t              mid;
    logic [8*MAX_DATA-1:0]       mid_cap;
    logic [8*(MAX_DATA+4)-1:0]   padded;
    logic                        done;
    logic                        do_capture;
    logic [1:0]                  n_len;
    logic [1:0]                  kind;
    logic [7:0]                  shown [4];

    always_comb
    begin
        mid        = cur_ctl;
        mid_cap    = cur_cap;
        done       = 1'b0;
        do_capture = 1'b0;
        n_len      = mtep_pkg::data_len(cur_ctl.run_status[6:4]);
        unique case (cur_ctl.phase)
            mtep_pkg::PH_STATUS:
            begin
                if (seq_byte == mtep_pkg::META_MARK)
                begin
                    mid.phase = mtep_pkg::PH_MTYPE;
                end
                else
                begin
                    mid.pend_meta = 1'b0;
                    if (seq_byte[7])
                    begin
                        mid.run_status  = seq_byte;
                        mid.pend_status = seq_byte;
                        mid.left        = {6'd0, mtep_pkg::data_len(seq_byte[6:4])};
                        mid.phase       = mtep_pkg::PH_DATA;
                    end
                    else
                    begin
                        mid.pend_status = cur_ctl.run_status;
                        do_capture      = 1'b1;
                        if (n_len <= 2'd1)
                        begin
                            done = 1'b1;
                        end
                        else
                        begin
                            mid.left  = {6'd0, n_len - 2'd1};
                            mid.phase = mtep_pkg::PH_DATA;
                        end
                    end
                end
            end
            mtep_pkg::PH_MTYPE:
            begin
                mid.pend_status = seq_byte;
                mid.pend_meta   = 1'b1;
                mid.phase       = mtep_pkg::PH_MLEN;
            end
            mtep_pkg::PH_MLEN:
            begin
                if (seq_byte == 8'd0)
                begin
                    done = 1'b1;
                end
                else
                begin
                    mid.left  = seq_byte;
                    mid.phase = mtep_pkg::PH_DATA;
                end
            end
            mtep_pkg::PH_DATA:
            begin
                do_capture = 1'b1;
                if (cur_ctl.left <= 8'd1)
                begin
                    done = 1'b1;
                end
                else
                begin
                    mid.left = cur_ctl.left - 8'd1;
                end
            end
            default:
            begin
                mid.delta = {cur_ctl.delta[24:0], seq_byte[6:0]};
                mid.phase = seq_byte[7] ? mtep_pkg::PH_DELTA : mtep_pkg::PH_STATUS;
            end
        endcase

        if (do_capture)
        begin
            for (int k = 0; k < MAX_DATA; k++)
            begin
                if (cur_ctl.count == 8'(k))
                begin
                    mid_cap[8*k +: 8] = seq_byte;
                end
            end
            if (cur_ctl.count != 8'd255)
            begin
                mid.count = cur_ctl.count + 8'd1;
            end
        end
    end

    assign padded = {32'd0, mid_cap};

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (k < MAX_DATA && 8'(k) < mid.count)
            begin
                shown[k] = padded[8*k +: 8];
            end
            else
            begin
                shown[k] = 8'd0;
            end
        end
    end

    always_comb
    begin
        kind = mtep_pkg::KIND_NONE;
        if (mid.pend_meta)
        begin
            if (mid.pend_status == mtep_pkg::META_END)
            begin
                kind = mtep_pkg::KIND_END;
            end
            else if (mid.pend_status == mtep_pkg::META_STOP)
            begin
                kind = mtep_pkg::KIND_STOP;
            end
        end
    end

    always_comb
    begin
        result.event_track = trk;
        result.delta_time  = mid.delta;
        result.status_byte = mid.pend_status;
        result.is_meta     = mid.pend_meta;
        result.data_0      = shown[0];
        result.data_1      = shown[1];
        result.data_2      = shown[2];
        result.data_3      = shown[3];
        result.data_count  = mid.count;
        result.truncated   = (32'(mid.count) > MAX_DATA);
        result.stop_kind   = kind;
    end

    // halted tracks ignore every byte
    always_comb
    begin
        nxt_ctl = mid;
        nxt_cap = mid_cap;
        emit    = 1'b0;
        if (cur_ctl.halt != 2'd0)
        begin
            nxt_ctl = cur_ctl;
            nxt_cap = cur_cap;
        end
        else if (done)
        begin
            emit          = 1'b1;
            nxt_ctl.phase = mtep_pkg::PH_DELTA;
            nxt_ctl.delta = 32'd0;
            nxt_ctl.count = 8'd0;
            nxt_ctl.left  = 8'd0;
            if (kind == mtep_pkg::KIND_END)
            begin
                nxt_ctl.halt = mid.halt | mtep_pkg::HALT_END;
            end
            else if (kind == mtep_pkg::KIND_STOP)
            begin
                nxt_ctl.halt = mid.halt | mtep_pkg::HALT_STOP;
            end
        end
    end

endmodule
